// ----- rtl/cts_pkg.sv -----
// ----------------------------------------------------------------------------
// cts_pkg
// shared types and constants for the cooperative task scheduler
// ----------------------------------------------------------------------------
package cts_pkg;

	localparam int MaxTasks = 16;
	localparam int IdW = $clog2(MaxTasks);
	localparam int CntW = $clog2(MaxTasks + 1);
	localparam logic [31:0] SingleShot = 32'hFFFF_FFFF;

	typedef enum logic [2:0] {
		OP_TICK = 3'd0, OP_CREATE = 3'd1, OP_SET_STATE = 3'd2, OP_SET_PERIOD = 3'd3,
		OP_DELAY = 3'd4, OP_ALL_OFF = 3'd5, OP_FINISH = 3'd6, OP_NONE = 3'd7
	} op_t;

	typedef enum logic [1:0] {
		ST_OFF = 2'd0, ST_READY = 2'd1, ST_ACTIVE = 2'd2, ST_BLOCKED = 2'd3
	} tstate_t;

	typedef enum logic [2:0] {
		ERR_OK = 3'd0, ERR_FULL = 3'd1, ERR_ID = 3'd2, ERR_ACTIVE = 3'd3, ERR_DELAY = 3'd4
	} err_t;

	typedef enum logic [0:0] { REG_WRAP = 1'b0, REG_MAXP = 1'b1 } reg_t;

	typedef enum logic [2:0] {
		S_IDLE, S_OFF, S_SCAN, S_DISP, S_DONE
	} seq_t;

	typedef struct packed {
		logic [2:0]  operation;
		logic [3:0]  task_id;
		logic [1:0]  new_state;
		logic [31:0] amount;
	} req_t;

	typedef struct packed {
		logic       active_valid;
		logic [3:0] active_task;
		logic       dispatched;
		logic [3:0] created_task;
		logic [2:0] error_code;
	} rsp_t;

	// adder request to the shared unit
	typedef struct packed {
		logic [31:0] a;
		logic [31:0] b;
		logic        sub;
	} alu_req_t;

endpackage

// ----- rtl/cts_alu.sv -----
// ----------------------------------------------------------------------------
// cts_alu
// shared 33-bit add/subtract unit with registered result
// ----------------------------------------------------------------------------
module cts_alu (
	input  logic              clk,
	input  cts_pkg::alu_req_t req,
	output logic [32:0]       res
);
	import cts_pkg::*;

	logic [32:0] res_q;

	always_ff @(posedge clk) begin
		if (req.sub) res_q <= {1'b0, req.a} - {1'b0, req.b};
		else         res_q <= {1'b0, req.a} + {1'b0, req.b};
	end

	assign res = res_q;
endmodule

// ----- rtl/cooperative_task_scheduler_top.sv -----
// ----------------------------------------------------------------------------
// cooperative_task_scheduler_top
// fixed-priority cooperative periodic task scheduler
// ----------------------------------------------------------------------------
// usage
//   command channel: req is taken at a clock edge with start high and busy low
//   busy rises the cycle after the transfer and stays high until the result
//   each command gives one result, shown on rsp for one cycle with done high;
//   the receiver cannot stall, so a result is simply presented once
//   config: cfg_we writes cfg_idx/cfg_data at once; user writes only while idle
// sequence of each command, from acceptance to its result
//   create, set state, set period, unknown op: straight from idle to the result
//   delayed start: two passes through the shared adder
//   all off: a walk over the task table, turning every task off
//   tick and finish: a scan over the task table, plus a dispatch pass through
//   the shared adder when a task is dispatched
//   finish with no task active: the scan ends before walking the table
//   the next command can be taken in the cycle after the result
//   the scan walks the task table one entry a cycle,
//   with one shared 33-bit adder doing every next-start sum
// reset
//   arst_n clears task count, tick counter, active task and the sequencer;
//   the task table itself is not cleared, entries are written by create
// ----------------------------------------------------------------------------
module cooperative_task_scheduler_top (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  cts_pkg::req_t req,
	output logic          done,
	output cts_pkg::rsp_t rsp,
	input  logic          cfg_we,
	input  logic          cfg_idx,
	input  logic [31:0]   cfg_data
);
	import cts_pkg::*;

	// task table memories
	logic [1:0]  state_mem [MaxTasks];
	logic [31:0] period_mem [MaxTasks];
	logic [31:0] next_mem [MaxTasks];

	logic [31:0] wrap_q, maxp_q, tick_q;
	logic [CntW-1:0] count_q;
	logic cur_v_q;
	logic [IdW-1:0] cur_q;

	seq_t st_q, st_d;
	req_t req_q;
	logic [CntW-1:0] idx_q;      // scan pointer
	logic [2:0] ph_q;            // sub step within a state
	logic have_act_q, have_rdy_q;
	logic [IdW-1:0] rdy_q;
	logic disp_q;
	err_t err_q;
	logic [IdW-1:0] created_q;
	logic [32:0] tmp_q;          // holds an intermediate sum with its carry

	alu_req_t alu_req;
	logic [32:0] alu_res;

	cts_alu u_alu (.clk(clk), .req(alu_req), .res(alu_res));

	logic [IdW-1:0] idx_w;
	assign idx_w = idx_q[IdW-1:0];

	// scan entry view, read combinationally from a small table at the scan pointer
	logic [1:0]  e_st;
	logic [31:0] e_per, e_nx;
	assign e_st  = state_mem[idx_w];
	assign e_per = period_mem[idx_w];
	assign e_nx  = next_mem[idx_w];

	logic [1:0] e_st_new;
	always_comb begin
		e_st_new = e_st;
		if (e_st == ST_BLOCKED && e_nx <= tick_q) begin
			if (!(e_nx < e_per && !(tick_q < e_per))) e_st_new = ST_READY;
		end
	end

	// next state
	always_comb begin
		st_d = st_q;
		unique case (st_q)
			S_IDLE: if (start) st_d = (req.operation == OP_ALL_OFF) ? S_OFF :
				(req.operation == OP_TICK || req.operation == OP_FINISH) ? S_SCAN :
				(req.operation == OP_DELAY) ? S_DISP : S_DONE;
			S_OFF: if (idx_q >= count_q) st_d = S_DONE;
			S_SCAN: begin
				if (ph_q != 3'd0 && idx_q >= count_q)
					st_d = (have_act_q || !have_rdy_q) ? S_DONE : S_DISP;
				if (ph_q == 3'd0 && req_q.operation == OP_FINISH && !cur_v_q) st_d = S_DONE;
			end
			S_DISP: if (ph_q == 3'd3) st_d = S_DONE;
			S_DONE: st_d = S_IDLE;
			default: st_d = S_IDLE;
		endcase
	end

	// shared adder operands
	always_comb begin
		alu_req = '{a: tick_q, b: req_q.amount, sub: 1'b0};
		if (req_q.operation == OP_DELAY) begin
			if (ph_q == 3'd0) alu_req = '{a: tick_q, b: req_q.amount, sub: 1'b0};
			else              alu_req = '{a: alu_res[31:0], b: wrap_q, sub: 1'b1};
		end else begin
			if (ph_q == 3'd0)      alu_req = '{a: tick_q, b: period_mem[rdy_q], sub: 1'b0};
			else if (ph_q == 3'd1) alu_req = '{a: wrap_q, b: tick_q, sub: 1'b1};
			else                   alu_req = '{a: period_mem[rdy_q], b: alu_res[31:0], sub: 1'b1};
		end
	end

	// outputs
	always_comb begin
		busy = (st_q != S_IDLE);
		done = (st_q == S_DONE);
		rsp.active_valid = cur_v_q;
		rsp.active_task  = cur_v_q ? 4'(cur_q) : 4'd0;
		rsp.dispatched   = disp_q;
		rsp.created_task = 4'(created_q);
		rsp.error_code   = err_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			wrap_q <= 32'd2147483647;
			maxp_q <= 32'd2147483647;
			tick_q <= '0;
			count_q <= '0;
			cur_v_q <= 1'b0;
			cur_q <= '0;
		end else begin
			st_q <= st_d;
			if (cfg_we) begin
				if (cfg_idx == REG_WRAP) wrap_q <= cfg_data;
				else maxp_q <= cfg_data;
			end
			if (st_q == S_IDLE && start && req.operation == OP_TICK)
				tick_q <= (tick_q < wrap_q) ? tick_q + 32'd1 : 32'd0;
			if (st_q == S_IDLE && start && req.operation == OP_CREATE &&
					!(req.amount > maxp_q && req.amount != SingleShot) &&
					count_q < CntW'(MaxTasks))
				count_q <= count_q + 1'b1;
			if (st_q == S_SCAN && ph_q != 3'd0 && idx_q >= count_q && !have_act_q) begin
				cur_v_q <= have_rdy_q;
				cur_q <= have_rdy_q ? rdy_q : '0;
			end
		end
	end

	// sequencer datapath and table
	always_ff @(posedge clk) begin
		unique case (st_q)
			S_IDLE: begin
				req_q <= req;
				idx_q <= '0;
				ph_q <= '0;
				have_act_q <= 1'b0;
				have_rdy_q <= 1'b0;
				rdy_q <= '0;
				disp_q <= 1'b0;
				err_q <= ERR_OK;
				created_q <= '0;
				if (start) begin
					unique case (req.operation)
						OP_CREATE: begin
							if ((req.amount > maxp_q && req.amount != SingleShot) ||
									count_q >= CntW'(MaxTasks))
								err_q <= ERR_FULL;
							else begin
								created_q <= count_q[IdW-1:0];
								state_mem[count_q[IdW-1:0]] <= ST_READY;
								period_mem[count_q[IdW-1:0]] <= req.amount;
								next_mem[count_q[IdW-1:0]] <= '0;
							end
						end
						OP_SET_STATE: begin
							if (req.new_state == ST_ACTIVE) err_q <= ERR_ACTIVE;
							else if (CntW'(req.task_id) >= count_q) err_q <= ERR_ID;
							else state_mem[req.task_id[IdW-1:0]] <= req.new_state;
						end
						OP_SET_PERIOD: begin
							if (CntW'(req.task_id) >= count_q) err_q <= ERR_ID;
							else period_mem[req.task_id[IdW-1:0]] <= req.amount;
						end
						OP_DELAY: begin
							if (CntW'(req.task_id) >= count_q) err_q <= ERR_ID;
							else if (req.amount >= SingleShot - wrap_q) err_q <= ERR_DELAY;
						end
						default: ;
					endcase
				end
			end
			S_OFF: begin
				if (idx_q < count_q) state_mem[idx_w] <= ST_OFF;
				idx_q <= idx_q + 1'b1;
			end
			S_SCAN: begin
				if (ph_q == 3'd0) begin
					// finish: demote the active task first
					ph_q <= 3'd1;
					if (req_q.operation == OP_FINISH && cur_v_q &&
							state_mem[cur_q] == ST_ACTIVE)
						state_mem[cur_q] <= ST_BLOCKED;
				end else if (idx_q < count_q) begin
					state_mem[idx_w] <= e_st_new;
					if (e_st_new == ST_ACTIVE) have_act_q <= 1'b1;
					if (!have_rdy_q && e_st_new == ST_READY) begin
						have_rdy_q <= 1'b1;
						rdy_q <= idx_w;
					end
					idx_q <= idx_q + 1'b1;
				end else
					ph_q <= 3'd0;
			end
			S_DISP: begin
				ph_q <= ph_q + 1'b1;
				if (req_q.operation == OP_DELAY) begin
					// phase 0 forms tick+delay, phase 1 has it, phase 2 has it-wrap
					// past the limit when the sum carried or its low word exceeds wrap
					if (ph_q == 3'd1) tmp_q <= alu_res;
					if (ph_q == 3'd2) begin
						if (err_q == ERR_OK) begin
							next_mem[req_q.task_id[IdW-1:0]] <=
								(tmp_q[32] || (!alu_res[32] && alu_res[31:0] != 32'd0)) ?
								alu_res[31:0] : tmp_q[31:0];
							if (state_mem[req_q.task_id[IdW-1:0]] == ST_OFF)
								state_mem[req_q.task_id[IdW-1:0]] <= ST_BLOCKED;
						end
					end
				end else begin
					// phase 1: tick+period, phase 2: wrap-tick, phase 3: period-(wrap-tick)
					if (ph_q == 3'd1) tmp_q <= alu_res;
					if (ph_q == 3'd3) begin
						disp_q <= 1'b1;
						state_mem[rdy_q] <= ST_ACTIVE;
						if (period_mem[rdy_q] == SingleShot) next_mem[rdy_q] <= SingleShot;
						else if (tmp_q <= {1'b0, wrap_q})
							next_mem[rdy_q] <= tmp_q[31:0];
						else next_mem[rdy_q] <= alu_res[31:0];
					end
				end
			end
			S_DONE: ;
			default: ;
		endcase
	end
endmodule

// ----- rtl/cts_checker.sv -----
// ----------------------------------------------------------------------------
// cts_checker
// port-level checks on the command channel
// ----------------------------------------------------------------------------
module cts_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          start,
	input logic          busy,
	input logic          done,
	input cts_pkg::rsp_t rsp
);
	import cts_pkg::*;

	a_busy_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("busy not raised");
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy) else $error("done while idle");
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("done longer than one cycle");
	a_err_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> rsp.error_code <= ERR_DELAY) else $error("bad error code");
	a_disp_active: assert property (@(posedge clk) disable iff (!arst_n)
		done && rsp.dispatched |-> rsp.active_valid) else $error("dispatch without active");
endmodule

bind cooperative_task_scheduler_top cts_checker u_chk (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done), .rsp(rsp)
);

// ----- test/tb_cooperative_task_scheduler_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_cooperative_task_scheduler_top
// self-checking bench for the cooperative task scheduler
// ----------------------------------------------------------------------------
// commands go in over the start/busy channel, results come back on done/rsp;
// a behavioral scheduler model predicts each result and a small scoreboard
// compares them in order; register writes happen only while the block is idle
// ----------------------------------------------------------------------------
module tb_cooperative_task_scheduler_top;
	import cts_pkg::*;

	// scheduler model plus queue of predicted responses
	class sched_scoreboard;
		logic [31:0] wrap_lim, max_per;
		tstate_t     st [MaxTasks];
		logic [31:0] per [MaxTasks];
		logic [31:0] nxt [MaxTasks];
		int unsigned tcount;
		bit          cur_v;
		int unsigned cur;
		logic [31:0] ticks;
		rsp_t        pending [$];
		int          errors;

		function void clear();
			wrap_lim = 32'h7FFF_FFFF;
			max_per = 32'h7FFF_FFFF;
			tcount = 0;
			cur_v = 0;
			cur = 0;
			ticks = 0;
			pending.delete();
			errors = 0;
		endfunction

		function void write_reg(reg_t idx, logic [31:0] val);
			if (idx == REG_WRAP) wrap_lim = val;
			else max_per = val;
		endfunction

		function bit scan();
			bit have_act, have_rdy;
			int unsigned rdy;
			logic [32:0] sum;
			have_act = 0;
			have_rdy = 0;
			rdy = 0;
			for (int i = 0; i < tcount; i++) begin
				if (st[i] == ST_BLOCKED && nxt[i] <= ticks) begin
					st[i] = ST_READY;
					if (nxt[i] < per[i] && !(ticks < per[i]))
						st[i] = ST_BLOCKED;
				end
				if (st[i] == ST_ACTIVE) have_act = 1;
				if (!have_rdy && st[i] == ST_READY) begin
					have_rdy = 1;
					rdy = i;
				end
			end
			if (have_act) return 0;
			if (!have_rdy) begin
				cur_v = 0;
				cur = 0;
				return 0;
			end
			cur_v = 1;
			cur = rdy;
			st[rdy] = ST_ACTIVE;
			if (per[rdy] == SingleShot) nxt[rdy] = SingleShot;
			else begin
				sum = {1'b0, ticks} + {1'b0, per[rdy]};
				if (sum <= {1'b0, wrap_lim}) nxt[rdy] = sum[31:0];
				else nxt[rdy] = per[rdy] - (wrap_lim - ticks);
			end
			return 1;
		endfunction

		// note an accepted command and queue its predicted response
		function void note_command(req_t r);
			rsp_t e;
			logic [32:0] nx;
			e = '0;
			case (op_t'(r.operation))
				OP_TICK: begin
					ticks = (ticks < wrap_lim) ? ticks + 1 : 0;
					e.dispatched = scan();
				end
				OP_CREATE: begin
					if ((r.amount > max_per && r.amount != SingleShot) || tcount >= MaxTasks)
						e.error_code = ERR_FULL;
					else begin
						e.created_task = 4'(tcount);
						st[tcount] = ST_READY;
						per[tcount] = r.amount;
						nxt[tcount] = 0;
						tcount++;
					end
				end
				OP_SET_STATE: begin
					if (tstate_t'(r.new_state) == ST_ACTIVE) e.error_code = ERR_ACTIVE;
					else if (r.task_id >= tcount) e.error_code = ERR_ID;
					else st[r.task_id] = tstate_t'(r.new_state);
				end
				OP_SET_PERIOD: begin
					if (r.task_id >= tcount) e.error_code = ERR_ID;
					else per[r.task_id] = r.amount;
				end
				OP_DELAY: begin
					if (r.task_id >= tcount) e.error_code = ERR_ID;
					else if (r.amount >= SingleShot - wrap_lim) e.error_code = ERR_DELAY;
					else begin
						nx = {1'b0, ticks} + {1'b0, r.amount};
						if (nx > {1'b0, wrap_lim}) nx = nx - {1'b0, wrap_lim};
						nxt[r.task_id] = nx[31:0];
						if (st[r.task_id] == ST_OFF) st[r.task_id] = ST_BLOCKED;
					end
				end
				OP_ALL_OFF: for (int i = 0; i < tcount; i++) st[i] = ST_OFF;
				OP_FINISH: if (cur_v) begin
					if (st[cur] == ST_ACTIVE) st[cur] = ST_BLOCKED;
					e.dispatched = scan();
				end
				default: ;
			endcase
			e.active_valid = cur_v;
			e.active_task = cur_v ? cur[3:0] : 4'd0;
			pending.push_back(e);
		endfunction

		task check_response(rsp_t got);
			rsp_t e;
			if (pending.size() == 0) begin
				report_mismatch("response with nothing pending", 0, 0);
				return;
			end
			e = pending.pop_front();
			if (got.active_valid !== e.active_valid)
				report_mismatch("active_valid", got.active_valid, e.active_valid);
			if (got.active_task !== e.active_task)
				report_mismatch("active_task", got.active_task, e.active_task);
			if (got.dispatched !== e.dispatched)
				report_mismatch("dispatched", got.dispatched, e.dispatched);
			if (got.created_task !== e.created_task)
				report_mismatch("created_task", got.created_task, e.created_task);
			if (got.error_code !== e.error_code)
				report_mismatch("error_code", got.error_code, e.error_code);
		endtask

		task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
			$display("mismatch %s: got %0h want %0h", what, got, want);
			errors++;
		endtask
	endclass

	logic          clk = 0;
	logic          arst_n = 0;
	logic          start = 0;
	logic          busy;
	req_t          req = '0;
	logic          done;
	rsp_t          rsp;
	logic          cfg_we = 0;
	logic          cfg_idx = 0;
	logic [31:0]   cfg_data = '0;

	sched_scoreboard sb = new();
	int          send_idle;   // percent of cycles the sender holds back
	longint      cycles = 0;

	always #2 clk = ~clk;

	cooperative_task_scheduler_top u_top (.*);

	// results cannot be held off, so check every strobe
	always @(posedge clk)
		if (arst_n && done) sb.check_response(rsp);

	// generous watchdog that ends the run with a failure
	always @(posedge clk) begin
		cycles++;
		if (cycles > 200000) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// one command transfer, with random gaps in front; start drops
	// after each transfer
	task automatic send_command(req_t r);
		while ($urandom_range(99) < send_idle) @(posedge clk);
		start <= 1;
		req <= r;
		@(posedge clk);
		while (busy) @(posedge clk);
		sb.note_command(r);
		start <= 0;
		@(posedge clk);
	endtask

	task automatic send(op_t op, int id, int ns, logic [31:0] amt);
		req_t r;
		r.operation = op;
		r.task_id = 4'(id);
		r.new_state = 2'(ns);
		r.amount = amt;
		send_command(r);
	endtask

	// wait for all responses, then let the tail of the block settle
	task automatic drain();
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	task automatic write_reg(reg_t idx, logic [31:0] val);
		drain();
		cfg_we <= 1;
		cfg_idx <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 0;
		sb.write_reg(idx, val);
	endtask

	function automatic logic [31:0] rand_amount();
		case ($urandom_range(5))
			0: return $urandom();
			1: return SingleShot;
			2: return $urandom_range(3, 0);
			default: return $urandom_range(40, 1);
		endcase
	endfunction

	// mostly ticks and finishes so tasks really run
	task automatic random_command(int ntasks);
		req_t r;
		int k;
		k = $urandom_range(99);
		r.task_id = 4'($urandom_range(15));
		if ($urandom_range(3) != 0 && ntasks > 0) r.task_id = 4'($urandom_range(ntasks - 1));
		r.new_state = 2'($urandom_range(3));
		r.amount = rand_amount();
		if (k < 40) r.operation = OP_TICK;
		else if (k < 60) r.operation = OP_FINISH;
		else if (k < 68) r.operation = OP_CREATE;
		else if (k < 78) r.operation = OP_SET_STATE;
		else if (k < 84) r.operation = OP_SET_PERIOD;
		else if (k < 93) r.operation = OP_DELAY;
		else if (k < 96) r.operation = OP_ALL_OFF;
		else r.operation = OP_NONE;
		send_command(r);
	endtask

	initial begin
		sb.clear();
		send_idle = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: errors on empty table, extremes, every op
		send(OP_FINISH, 0, 0, 0);
		send(OP_SET_STATE, 0, ST_ACTIVE, 0);
		send(OP_SET_STATE, 15, ST_READY, 0);
		send(OP_SET_PERIOD, 3, 0, 5);
		send(OP_DELAY, 0, 0, 1);
		send(OP_CREATE, 0, 0, 32'h8000_0000);
		send(OP_CREATE, 0, 0, 32'h7FFF_FFFF);
		send(OP_CREATE, 0, 0, SingleShot);
		send(OP_CREATE, 0, 0, 2);
		send(OP_TICK, 0, 0, 0);
		send(OP_FINISH, 0, 0, 0);
		send(OP_FINISH, 0, 0, 0);
		send(OP_DELAY, 1, 0, 32'h8000_0000);
		send(OP_DELAY, 2, 0, 3);
		send(OP_SET_STATE, 2, ST_OFF, 0);
		send(OP_DELAY, 2, 0, 32'h7FFF_FFFF);
		send(OP_ALL_OFF, 0, 0, 0);
		send(OP_TICK, 0, 0, 0);
		send(OP_SET_STATE, 1, ST_BLOCKED, 0);
		send(OP_NONE, 15, 3, SingleShot);
		for (int i = 0; i < 14; i++) send(OP_CREATE, 0, 0, i);
		send(OP_SET_STATE, 15, ST_READY, 0);

		// small wrap limit to exercise the wrap rules, tiny periods allowed
		write_reg(REG_WRAP, 1);
		write_reg(REG_MAXP, 1);
		arst_cycle_phase(150, 24);
		write_reg(REG_WRAP, 20);
		write_reg(REG_MAXP, 32'hFFFF_FFFE);
		arst_cycle_phase(300, 53);
		drain();   // sender waits for every result
		write_reg(REG_WRAP, 32'hFFFF_FFFE);
		write_reg(REG_MAXP, 30);
		arst_cycle_phase(250, 0);
		write_reg(REG_WRAP, 7);
		write_reg(REG_MAXP, 10);
		arst_cycle_phase(300, 0);

		drain();
		if (sb.errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	// a random phase; all off turns tasks off but frees no entries, so a full table stays full
	task automatic arst_cycle_phase(int n, int idle);
		send_idle = idle;
		for (int i = 0; i < n; i++) random_command(sb.tcount);
	endtask

endmodule

// ----- filelist.f -----
rtl/cts_pkg.sv
rtl/cts_alu.sv
rtl/cooperative_task_scheduler_top.sv
rtl/cts_checker.sv
test/tb_cooperative_task_scheduler_top.sv
